/* hdl/wtlq_pkg.sv */
// ----------------------------------------------------------------------------
// wtlq_pkg
// Types and constants shared by the wheel tach / line qualifier / PWM unit.
// ----------------------------------------------------------------------------
package wtlq_pkg;

  localparam int NUM_WHEELS  = 4;
  localparam int NUM_LINES   = 3;
  localparam int TIME_W      = 16;
  localparam int COUNT_W     = 8;
  localparam int EDGE_W      = 32;
  localparam int DUTY_W      = 8;
  localparam int QUAL_W      = 8;
  localparam int DUTY_FULL   = 255;
  localparam int DIST_WHEEL  = 3;

  localparam logic [QUAL_W-1:0] QUALIFY_RESET = 8'd30;

  typedef struct packed {
    logic [TIME_W-1:0]     now_time;
    logic [NUM_WHEELS-1:0] wheel_pins;
    logic [NUM_LINES-1:0]  line_pins;
    logic [DUTY_W-1:0]     duty_a;
    logic [DUTY_W-1:0]     duty_b;
    logic                  long_qualify;
  } in_word_t;

  typedef struct packed {
    logic                pwm_a;
    logic                pwm_b;
    logic [COUNT_W-1:0]  mark_count_0;
    logic [COUNT_W-1:0]  mark_count_1;
    logic [COUNT_W-1:0]  mark_count_2;
    logic [EDGE_W-1:0]   distance_edges;
    logic [TIME_W-1:0]   span_sum;
    logic [TIME_W-1:0]   last_width;
  } out_word_t;

endpackage

/* hdl/wheel_tach_line_qualifier_pwm_unit.sv */
// ----------------------------------------------------------------------------
// wheel_tach_line_qualifier_pwm_unit
// The input register loads at the accept edge, and the result register loads
// when the word leaves the update stage, which waits while the output stalls.
// Throughput: one word per cycle while the output is not stalled, set by the
// single update stage between the two registers.
// Reset: async active low; all state, counters and history cleared, the
// qualify threshold returns to 30, both word registers empty.
// ----------------------------------------------------------------------------
module wheel_tach_line_qualifier_pwm_unit #(
  parameter int PWM_PERIOD    = 1000,
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  wtlq_pkg::in_word_t        in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output wtlq_pkg::out_word_t       out_word_o
);
  import wtlq_pkg::*;

  localparam int PH_W  = (PWM_PERIOD > 2) ? $clog2(PWM_PERIOD) : 1;
  localparam int PRD_W = PH_W + DUTY_W;
  localparam int NEWEST = HISTORY_DEPTH - 1;

  logic [QUAL_W-1:0]     qual_q;
  in_word_t              in_q;
  logic                  s1_q;
  out_word_t             out_q, out_d;
  logic                  out_valid_q;
  logic                  out_free, s2_go, in_go;

  logic [NUM_WHEELS-1:0] wheel_prev_q;
  logic [NUM_LINES-1:0]  line_prev_q;
  logic [TIME_W-1:0]     hist_q [NUM_WHEELS][HISTORY_DEPTH];
  logic [TIME_W-1:0]     hist_d [NUM_WHEELS][HISTORY_DEPTH];
  logic [TIME_W-1:0]     fall_q [NUM_LINES];
  logic [TIME_W-1:0]     fall_d [NUM_LINES];
  logic [COUNT_W-1:0]    cnt_q  [NUM_LINES];
  logic [COUNT_W-1:0]    cnt_d  [NUM_LINES];
  logic [EDGE_W-1:0]     edge_q, edge_d;
  logic [PH_W-1:0]       phase_q, phase_d;
  logic [TIME_W-1:0]     width_q, width_d;

  logic [QUAL_W:0]       thr;
  logic [TIME_W-1:0]     low_w [NUM_LINES];
  logic [TIME_W-1:0]     span;
  logic [PRD_W-1:0]      phase_scaled, lim_a, lim_b;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s2_go       = s1_q && out_free;
  assign in_stall_o  = s1_q && !out_free;
  assign in_go       = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    thr = in_q.long_qualify ? {qual_q, 1'b0} : {1'b0, qual_q};

    for (int w = 0; w < NUM_WHEELS; w++) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_d[w][k] = hist_q[w][k];
      end
      if (in_q.wheel_pins[w] && !wheel_prev_q[w]) begin
        for (int k = 0; k < NEWEST; k++) begin
          hist_d[w][k] = hist_q[w][k+1];
        end
        hist_d[w][NEWEST] = in_q.now_time;
      end
    end

    edge_d = edge_q;
    if (in_q.wheel_pins[DIST_WHEEL] != wheel_prev_q[DIST_WHEEL]) begin
      edge_d = edge_q + EDGE_W'(1);
    end

    width_d = width_q;
    for (int l = 0; l < NUM_LINES; l++) begin
      fall_d[l] = fall_q[l];
      cnt_d[l]  = cnt_q[l];
      low_w[l]  = in_q.now_time - fall_q[l];
      if (in_q.line_pins[l] != line_prev_q[l]) begin
        if (!in_q.line_pins[l]) begin
          fall_d[l] = in_q.now_time;
        end else if (low_w[l] >= TIME_W'(thr)) begin
          cnt_d[l] = cnt_q[l] + COUNT_W'(1);
          if (l == 0) begin
            width_d = low_w[l];
          end
        end
      end
    end

    phase_d = (phase_q == PH_W'(PWM_PERIOD - 1)) ? '0 : phase_q + PH_W'(1);

    span = '0;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      span = span + (hist_d[w][NEWEST] - hist_d[w][0]);
    end

    // phase <= floor(duty*P/255)  <=>  phase*255 <= duty*P
    phase_scaled = PRD_W'(phase_d) * PRD_W'(DUTY_FULL);
    lim_a        = PRD_W'(in_q.duty_a) * PRD_W'(PWM_PERIOD);
    lim_b        = PRD_W'(in_q.duty_b) * PRD_W'(PWM_PERIOD);

    out_d.pwm_a          = phase_scaled > lim_a;
    out_d.pwm_b          = phase_scaled > lim_b;
    out_d.mark_count_0   = cnt_d[0];
    out_d.mark_count_1   = cnt_d[1];
    out_d.mark_count_2   = cnt_d[2];
    out_d.distance_edges = edge_d;
    out_d.span_sum       = span;
    out_d.last_width     = width_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qual_q       <= QUALIFY_RESET;
      s1_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      wheel_prev_q <= '0;
      line_prev_q  <= '0;
      edge_q       <= '0;
      phase_q      <= '0;
      width_q      <= '0;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          hist_q[w][k] <= '0;
        end
      end
      for (int l = 0; l < NUM_LINES; l++) begin
        fall_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        qual_q <= cfg_data_i;
      end
      if (in_go) begin
        s1_q <= 1'b1;
      end else if (s2_go) begin
        s1_q <= 1'b0;
      end
      if (s2_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s2_go) begin
        wheel_prev_q <= in_q.wheel_pins;
        line_prev_q  <= in_q.line_pins;
        edge_q       <= edge_d;
        phase_q      <= phase_d;
        width_q      <= width_d;
        hist_q       <= hist_d;
        fall_q       <= fall_d;
        cnt_q        <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      in_q <= in_word_i;
    end
    if (s2_go) begin
      out_q <= out_d;
    end
  end

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_q && out_valid_q))
    else $error("input stalled while a register stage is empty");

  a_edge_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (EDGE_W'(edge_q - $past(edge_q)) <= EDGE_W'(1)))
    else $error("distance count moved by more than one");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_go |=> (phase_q <= PH_W'(PWM_PERIOD - 1)))
    else $error("pwm phase out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_go |=> ($stable(edge_q) && $stable(phase_q) && $stable(width_q)))
    else $error("state changed without a word passing");

endmodule

/* dv/wheel_tach_line_qualifier_pwm_unit_tb.sv */
// ----------------------------------------------------------------------------
// wheel_tach_line_qualifier_pwm_unit_tb
// Self-checking bench for the wheel tach / line qualifier / PWM unit. Sends
// directed and random tick words, predicts every result word with a local
// model of the unit, and compares each field. Both channels idle and stall at
// random, and the threshold is rewritten between runs.
// ----------------------------------------------------------------------------
module wheel_tach_line_qualifier_pwm_unit_tb;
  import wtlq_pkg::*;

  localparam int PWM_PERIOD    = 1000;
  localparam int HISTORY_DEPTH = 5;
  localparam int MAX_CYCLES    = 300000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 4;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  in_word_t   in_word_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_word_t  out_word_o;

  wheel_tach_line_qualifier_pwm_unit #(
    .PWM_PERIOD    (PWM_PERIOD),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // model state
  logic [QUAL_W-1:0]     qualify_set = QUALIFY_RESET;
  logic [NUM_WHEELS-1:0] wheel_last  = '0;
  logic [NUM_LINES-1:0]  line_last   = '0;
  logic [TIME_W-1:0]     hist_time [NUM_WHEELS][HISTORY_DEPTH];
  logic [TIME_W-1:0]     fall_stamp [NUM_LINES];
  logic [COUNT_W-1:0]    mark_cnt [NUM_LINES];
  logic [EDGE_W-1:0]     dist_edges  = '0;
  int unsigned           pwm_cnt     = 0;
  logic [TIME_W-1:0]     width_q0    = '0;

  out_word_t   pending_readings [$];
  int unsigned readings_checked = 0;
  int unsigned words_sent       = 0;
  int unsigned mismatches       = 0;
  int unsigned cycle_count      = 0;
  int unsigned in_hold_cycles   = 0;

  // stimulus state
  logic [TIME_W-1:0]     stim_time;
  logic [NUM_WHEELS-1:0] stim_wheel;
  logic [NUM_LINES-1:0]  stim_line;
  logic                  burst_mode = 1'b0;
  logic                  hold_req   = 1'b0;

  initial begin
    for (int i = 0; i < NUM_WHEELS; i++)
      for (int k = 0; k < HISTORY_DEPTH; k++) hist_time[i][k] = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      fall_stamp[i] = '0;
      mark_cnt[i]   = '0;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_word_t tick_model(in_word_t w);
    out_word_t         r;
    logic [8:0]        thr;
    logic [TIME_W-1:0] lo_width;
    logic [TIME_W-1:0] span;
    int unsigned       lim_a;
    int unsigned       lim_b;
    thr = w.long_qualify ? {qualify_set, 1'b0} : {1'b0, qualify_set};
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (w.wheel_pins[i] != wheel_last[i]) begin
        if (w.wheel_pins[i]) begin
          for (int k = 0; k < HISTORY_DEPTH - 1; k++) hist_time[i][k] = hist_time[i][k+1];
          hist_time[i][HISTORY_DEPTH-1] = w.now_time;
        end
        if (i == DIST_WHEEL) dist_edges = dist_edges + 1'b1;
      end
    end
    wheel_last = w.wheel_pins;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (w.line_pins[i] != line_last[i]) begin
        if (!w.line_pins[i]) begin
          fall_stamp[i] = w.now_time;
        end else begin
          lo_width = w.now_time - fall_stamp[i];
          if (lo_width >= {7'd0, thr}) begin
            mark_cnt[i] = mark_cnt[i] + 1'b1;
            if (i == 0) width_q0 = lo_width;
          end
        end
      end
    end
    line_last = w.line_pins;
    pwm_cnt = (pwm_cnt + 1 >= PWM_PERIOD) ? 0 : pwm_cnt + 1;
    span = '0;
    for (int i = 0; i < NUM_WHEELS; i++)
      span = span + (hist_time[i][HISTORY_DEPTH-1] - hist_time[i][0]);
    lim_a = int'(w.duty_a) * PWM_PERIOD / DUTY_FULL;
    lim_b = int'(w.duty_b) * PWM_PERIOD / DUTY_FULL;
    r.pwm_a          = (pwm_cnt <= lim_a) ? 1'b0 : 1'b1;
    r.pwm_b          = (pwm_cnt <= lim_b) ? 1'b0 : 1'b1;
    r.mark_count_0   = mark_cnt[0];
    r.mark_count_1   = mark_cnt[1];
    r.mark_count_2   = mark_cnt[2];
    r.distance_edges = dist_edges;
    r.span_sum       = span;
    r.last_width     = width_q0;
    return r;
  endfunction

  function automatic in_word_t tick_word(logic [TIME_W-1:0] t, logic [NUM_WHEELS-1:0] wp,
                                         logic [NUM_LINES-1:0] lp, logic [DUTY_W-1:0] da,
                                         logic [DUTY_W-1:0] db, logic lq);
    in_word_t w;
    w.now_time     = t;
    w.wheel_pins   = wp;
    w.line_pins    = lp;
    w.duty_a       = da;
    w.duty_b       = db;
    w.long_qualify = lq;
    return w;
  endfunction

  function automatic logic [DUTY_W-1:0] random_duty();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return DUTY_W'(DUTY_FULL);
    return DUTY_W'($urandom);
  endfunction

  // mostly small time steps so line pulses land near the threshold
  function automatic in_word_t random_tick();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      stim_time = stim_time + TIME_W'($urandom_range(0, 40));
    else if (pick < 95) stim_time = stim_time + TIME_W'($urandom_range(0, 600));
    else                stim_time = TIME_W'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      stim_wheel = NUM_WHEELS'($urandom);
      stim_line  = NUM_LINES'($urandom);
    end else begin
      for (int i = 0; i < NUM_WHEELS; i++)
        if ($urandom_range(0, 2) == 0) stim_wheel[i] = ~stim_wheel[i];
      for (int i = 0; i < NUM_LINES; i++)
        if ($urandom_range(0, 3) == 0) stim_line[i] = ~stim_line[i];
    end
    return tick_word(stim_time, stim_wheel, stim_line, random_duty(), random_duty(),
                     1'($urandom));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at word %0d, %s: got %0h, expected %0h",
               readings_checked, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected word", out_word_o.distance_edges, '0);
      end else begin
        out_word_t want;
        want = pending_readings.pop_front();
        check_field("pwm_a", out_word_o.pwm_a, want.pwm_a);
        check_field("pwm_b", out_word_o.pwm_b, want.pwm_b);
        check_field("mark_count_0", out_word_o.mark_count_0, want.mark_count_0);
        check_field("mark_count_1", out_word_o.mark_count_1, want.mark_count_1);
        check_field("mark_count_2", out_word_o.mark_count_2, want.mark_count_2);
        check_field("distance_edges", out_word_o.distance_edges, want.distance_edges);
        check_field("span_sum", out_word_o.span_sum, want.span_sum);
        check_field("last_width", out_word_o.last_width, want.last_width);
      end
      readings_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && in_valid_i && in_stall_o) in_hold_cycles <= in_hold_cycles + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall per word, plus one long hold on request
  initial begin
    int unsigned stall_len;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_len = HOLD_CYCLES;
      end else begin
        stall_len = burst_mode ? 0 : $urandom_range(0, 11);
      end
      if (stall_len > 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (stall_len - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_word_i  = w;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(tick_model(w));
    words_sent++;
  endtask

  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_qualify(logic [QUAL_W-1:0] v);
    settle_idle();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    qualify_set = v;
  endtask

  // all pins high on the first tick count as rising edges; pulse widths just
  // under and at the threshold; a low time that spans the timestamp wrap
  task automatic test_first_tick();
    send_word(tick_word(16'd100,   4'hF, 3'b111, 8'd0,   8'd255, 1'b0));
    send_word(tick_word(16'd200,   4'h0, 3'b000, 8'd255, 8'd0,   1'b0));
    send_word(tick_word(16'd229,   4'hF, 3'b001, 8'd128, 8'd127, 1'b0));
    send_word(tick_word(16'd230,   4'h0, 3'b000, 8'd1,   8'd254, 1'b0));
    send_word(tick_word(16'd260,   4'hF, 3'b011, 8'd255, 8'd255, 1'b0));
    send_word(tick_word(16'd65530, 4'h0, 3'b000, 8'd0,   8'd0,   1'b0));
    send_word(tick_word(16'd20,    4'hF, 3'b111, 8'd1,   8'd254, 1'b1));
  endtask

  task automatic test_qualify_extremes();
    write_qualify(8'd0);
    send_word(tick_word(16'd500,  4'h0, 3'b000, 8'd10,  8'd200, 1'b0));
    send_word(tick_word(16'd500,  4'hF, 3'b111, 8'd10,  8'd200, 1'b1));
    write_qualify(8'd255);
    send_word(tick_word(16'd1000, 4'h0, 3'b000, 8'd0,   8'd255, 1'b1));
    send_word(tick_word(16'd1509, 4'hF, 3'b111, 8'd0,   8'd255, 1'b1));
    send_word(tick_word(16'd2000, 4'h0, 3'b000, 8'd255, 8'd0,   1'b1));
    send_word(tick_word(16'd2510, 4'hF, 3'b111, 8'd255, 8'd0,   1'b1));
    send_word(tick_word(16'd3000, 4'h0, 3'b000, 8'd64,  8'd192, 1'b0));
    send_word(tick_word(16'd3254, 4'hF, 3'b111, 8'd64,  8'd192, 1'b0));
    send_word(tick_word(16'd3300, 4'h0, 3'b000, 8'd64,  8'd192, 1'b0));
    send_word(tick_word(16'd3555, 4'hF, 3'b111, 8'd64,  8'd192, 1'b0));
  endtask

  // enough rising edges to roll every history across the timestamp wrap
  task automatic test_wheel_history();
    send_word(tick_word(16'd65533, 4'h0, 3'b111, 8'd255, 8'd0, 1'b0));
    send_word(tick_word(16'd65534, 4'hF, 3'b111, 8'd255, 8'd0, 1'b0));
    send_word(tick_word(16'd65535, 4'h0, 3'b111, 8'd255, 8'd0, 1'b0));
    send_word(tick_word(16'd0,     4'hF, 3'b111, 8'd255, 8'd0, 1'b0));
    send_word(tick_word(16'd3,     4'h0, 3'b111, 8'd255, 8'd0, 1'b0));
    send_word(tick_word(16'd7,     4'hF, 3'b111, 8'd255, 8'd0, 1'b0));
  endtask

  task automatic test_backpressure();
    stim_time  = TIME_W'($urandom);
    stim_wheel = '0;
    stim_line  = '1;
    hold_req   = 1'b1;
    burst_mode = 1'b1;
    for (int i = 0; i < 40; i++) send_word(random_tick());
    burst_mode = 1'b0;
  endtask

  task automatic test_random_run(logic [QUAL_W-1:0] q, int unsigned n);
    write_qualify(q);
    stim_time = TIME_W'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      burst_mode = ((i % 120) < 20);
      send_word(random_tick());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_tick();
    test_qualify_extremes();
    test_wheel_history();
    test_backpressure();
    test_random_run(8'd30, 230);
    test_random_run(8'd0, 230);
    test_random_run(8'd255, 230);
    test_random_run(8'd1, 230);
    test_random_run(QUAL_W'($urandom), 230);
    test_random_run(8'd128, 230);
    settle_idle();

    $display("run covered %0d words (%0d checked), thresholds 0, 1, 30, 128, 255 and random",
             words_sent, readings_checked);
    $display("input held off for %0d cycles during output stalls", in_hold_cycles);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
